### hdl/dbrb_pkg.sv
// ---------------------------------------------------------------------------
// dbrb_pkg: shared types and constants for the dirty block range bitmap
// holds the map geometry, beat structs and sequencer state encoding
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbrb_pkg;

  localparam int NUM_BLOCKS = 65536;
  localparam int MAP_WORDS  = (NUM_BLOCKS + 31) / 32;
  localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WORD_W     = 32;
  localparam int BIT_AW     = 5;
  localparam int BLK_W      = 16;
  localparam int CNT_W      = 17;
  localparam int POP_W      = 6;

  // block count cap, kept within the register width
  localparam logic [CNT_W-1:0] NB_CAP =
    (NUM_BLOCKS > (2 ** CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] TOTAL_BLOCKS_RST = CNT_W'(65536);
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);

  localparam logic FUNC_MARK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic             func;
    logic [BLK_W-1:0] start_block;
    logic [BLK_W-1:0] end_block;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] dirty_count;
    logic [CNT_W-1:0] newly_marked;
  } res_t;

  // per-word control for the word unit
  typedef struct packed {
    logic              first;
    logic              last;
    logic [BIT_AW-1:0] lo;
    logic [BIT_AW-1:0] hi;
  } word_ctl_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_CLEAR
  } st_e;

endpackage

### hdl/dbrb_ram.sv
// ---------------------------------------------------------------------------
// dbrb_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbrb_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/dbrb_word_unit.sv
// ---------------------------------------------------------------------------
// dbrb_word_unit: word update unit
// builds the range mask for one map word, merges it and counts new marks
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbrb_word_unit (
  input  dbrb_pkg::word_ctl_t                 ctl_i,
  input  logic [dbrb_pkg::WORD_W-1:0]         rdata_i,
  output logic [dbrb_pkg::WORD_W-1:0]         wdata_o,
  output logic [dbrb_pkg::POP_W-1:0]          pop_o
);

  import dbrb_pkg::*;

  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] fresh_bits;

  always_comb begin
    lo_mask    = ctl_i.first ? ({WORD_W{1'b1}} << ctl_i.lo) : {WORD_W{1'b1}};
    hi_mask    = ctl_i.last ? ({WORD_W{1'b1}} >> (BIT_AW'(WORD_W - 1) - ctl_i.hi))
                            : {WORD_W{1'b1}};
    mask       = lo_mask & hi_mask;
    fresh_bits = mask & ~rdata_i;
    wdata_o    = rdata_i | mask;
    pop_o      = POP_W'($countones(fresh_bits));
  end

endmodule

### hdl/dirty_block_range_bitmap.sv
// ---------------------------------------------------------------------------
// dirty_block_range_bitmap: dirty block tracking bitmap with range marking
// one dirty bit per block in a word ram, walked one word per cycle
// ---------------------------------------------------------------------------
//
//   channel   handshake                  payload
//   -------   ------------------------   ---------------------------------
//   request   start / busy               req_i    (func, start, end block)
//   result    result_valid_o (strobe)    result_o (dirty count, new marks)
//   config    cfg_valid_i / cfg_ready_o  cfg_data_i (total_blocks)
//
// a mark beat keeps busy high while it walks its map words and drains, the result
//   strobes in the cycle after; the word ram read-modify-write sets the pace
// a clear beat walks all MAP_WORDS words writing zeros
// an ignored mark answers in the cycle after its request
// after reset the same wipe runs once before start is taken
// results are not back-pressured; cfg writes are taken in any cycle
//
`timescale 1ns / 1ps

module dirty_block_range_bitmap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  dbrb_pkg::req_t              req_i,
  output dbrb_pkg::res_t              result_o,
  output logic                        result_valid_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dbrb_pkg::CNT_W-1:0]  cfg_data_i
);

  import dbrb_pkg::*;

  // sequencer state
  st_e                state_q, state_d;
  logic [WORD_AW-1:0] addr_q, addr_d;      // next word to read or wipe
  logic [WORD_AW-1:0] first_q, first_d;    // first word of the range
  logic [WORD_AW-1:0] last_q, last_d;      // last word of the range
  logic [BIT_AW-1:0]  lo_q, lo_d;          // bit of the first block in its word
  logic [BIT_AW-1:0]  hi_q, hi_d;          // bit of the last block in its word
  logic               rd_vld_q, rd_vld_d;  // ram read data valid this cycle
  logic [WORD_AW-1:0] rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]   fresh_q, fresh_d;    // new marks so far
  logic [CNT_W-1:0]   total_q, total_d;    // running dirty total
  logic [CNT_W-1:0]   tblk_q, tblk_d;      // total_blocks register
  res_t               res_q, res_d;
  logic               res_vld_q, res_vld_d;

  // ram ports
  logic               ram_we;
  logic [WORD_AW-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [WORD_W-1:0]  ram_rdata;

  // word unit
  word_ctl_t          wctl;
  logic [WORD_W-1:0]  unit_wdata;
  logic [POP_W-1:0]   unit_pop;

  // range decode at the request
  logic [CNT_W-1:0]   max_blk;
  logic [CNT_W-1:0]   end_ext;
  logic [CNT_W-1:0]   end_eff;
  logic               range_ok;
  logic [CNT_W-1:0]   fresh_sum;

  dbrb_ram #(
    .Width (WORD_W),
    .Depth (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign wctl.first = (rd_addr_q == first_q);
  assign wctl.last  = (rd_addr_q == last_q);
  assign wctl.lo    = lo_q;
  assign wctl.hi    = hi_q;

  dbrb_word_unit u_word_unit (
    .ctl_i   (wctl),
    .rdata_i (ram_rdata),
    .wdata_o (unit_wdata),
    .pop_o   (unit_pop)
  );

  // clamp the range against the tracked block count
  always_comb begin
    max_blk  = (tblk_q > NB_CAP) ? NB_CAP : tblk_q;
    end_ext  = CNT_W'(req_i.end_block);
    end_eff  = (end_ext >= max_blk) ? (max_blk - CNT_W'(1)) : end_ext;
    range_ok = (max_blk != '0) && (CNT_W'(req_i.start_block) <= end_eff);
  end

  assign fresh_sum = fresh_q + CNT_W'(unit_pop);

  // config register, always ready
  assign cfg_ready_o = 1'b1;
  assign tblk_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : tblk_q;

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    first_d   = first_q;
    last_d    = last_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    rd_vld_d  = 1'b0;
    rd_addr_d = rd_addr_q;
    fresh_d   = fresh_q;
    total_d   = total_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = rd_addr_q;
    ram_wdata = unit_wdata;
    ram_re    = 1'b0;

    // write back the word read in the previous cycle
    if (rd_vld_q) begin
      ram_we  = 1'b1;
      fresh_d = fresh_sum;
    end

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = '0;
        addr_d    = addr_q + WORD_AW'(1);
        if (addr_q == LAST_WORD) begin
          state_d = ST_IDLE;
          addr_d  = '0;
          if (state_q == ST_CLEAR) begin
            total_d   = '0;
            res_d     = '0;
            res_vld_d = 1'b1;
          end
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (req_i.func == FUNC_CLEAR) begin
            state_d = ST_CLEAR;
            addr_d  = '0;
          end else if (range_ok) begin
            state_d = ST_WALK;
            addr_d  = WORD_AW'(req_i.start_block >> BIT_AW);
            first_d = WORD_AW'(req_i.start_block >> BIT_AW);
            last_d  = WORD_AW'(end_eff >> BIT_AW);
            lo_d    = req_i.start_block[BIT_AW-1:0];
            hi_d    = end_eff[BIT_AW-1:0];
            fresh_d = '0;
          end else begin
            res_d.dirty_count  = total_q;
            res_d.newly_marked = '0;
            res_vld_d          = 1'b1;
          end
        end
      end
      ST_WALK: begin
        ram_re    = 1'b1;
        rd_vld_d  = 1'b1;
        rd_addr_d = addr_q;
        addr_d    = addr_q + WORD_AW'(1);
        if (addr_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last word is written back this cycle
        total_d            = total_q + fresh_sum;
        res_d.dirty_count  = total_q + fresh_sum;
        res_d.newly_marked = fresh_sum;
        res_vld_d          = 1'b1;
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      addr_q    <= '0;
      rd_vld_q  <= 1'b0;
      total_q   <= '0;
      tblk_q    <= TOTAL_BLOCKS_RST;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      rd_vld_q  <= rd_vld_d;
      total_q   <= total_d;
      tblk_q    <= tblk_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    first_q   <= first_d;
    last_q    <= last_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    rd_addr_q <= rd_addr_d;
    fresh_q   <= fresh_d;
    res_q     <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

endmodule
